@@ hdl/tcw_pkg.sv @@
// shared types and constants for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // field widths of the command and response words
    localparam int KIND_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int COLOR_W    = 4;
    localparam int CELL_W     = CHAR_W + 2 * COLOR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLOR_W;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_PUT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

    // reset colors and the character used by a screen clear
    localparam logic [COLOR_W-1:0] FG_RESET    = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET    = 4'd0;
    localparam logic [CHAR_W-1:0]  BLANK_SPACE = 8'h20;

    // controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_INIT_DONE,
        S_IDLE,
        S_READ,
        S_COPY,
        S_BLANK,
        S_DONE_SCROLL,
        S_CLEAR,
        S_DONE_CLEAR
    } state_t;

    // what one step of a store walk writes
    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_COPY,
        WALK_ZERO,
        WALK_FILL
    } walk_mode_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       accept;
        logic       idx_clear;
        logic       idx_to_blank;
        logic       idx_inc;
        walk_mode_t walk;
        logic       out_load;
        logic       out_scroll;
        logic       out_cell;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic wrap_col;
        logic last_row;
        logic copy_end;
        logic walk_end;
    } status_t;

endpackage

@@ hdl/tcw_cmd_if.sv @@
// command channel: one console command per word
`timescale 1ns / 1ps

interface tcw_cmd_if import tcw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   character;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;

    modport source (output valid, kind, character, column, row, input ready);
    modport sink   (input valid, kind, character, column, row, output ready);
endinterface

@@ hdl/tcw_rsp_if.sv @@
// response channel: cursor and cell read-back per word
`timescale 1ns / 1ps

interface tcw_rsp_if import tcw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic                did_scroll;
    logic [CHAR_W-1:0]   cell_character;
    logic [COLOR_W-1:0]  cell_foreground;
    logic [COLOR_W-1:0]  cell_background;

    modport source (output valid, cursor_column, cursor_row, did_scroll,
                     cell_character, cell_foreground, cell_background, input ready);
    modport sink   (input valid, cursor_column, cursor_row, did_scroll,
                     cell_character, cell_foreground, cell_background, output ready);
endinterface

@@ hdl/tcw_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tcw_ctrl.sv @@
// console controller: handshakes, store walks and response timing
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [KIND_W-1:0] kind,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  status_t           stat,
    output ctrl_t             ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   in_ready;

    // state and response valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // take a word only when idle and the response register frees up
    assign in_ready  = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = in_ready;
    assign rsp_valid = rsp_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next        = state_reg;
        ctrl.accept       = 1'b0;
        ctrl.idx_clear    = 1'b0;
        ctrl.idx_to_blank = 1'b0;
        ctrl.idx_inc      = 1'b0;
        ctrl.walk         = WALK_NONE;
        ctrl.out_load     = 1'b0;
        ctrl.out_scroll   = 1'b0;
        ctrl.out_cell     = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                ctrl.walk = WALK_ZERO;
                if (stat.walk_end)
                begin
                    state_next = S_INIT_DONE;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_INIT_DONE:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_ready && cmd_valid)
                begin
                    ctrl.accept = 1'b1;
                    case (kind)
                        KIND_PUT:
                        begin
                            if (stat.wrap_col && stat.last_row)
                            begin
                                ctrl.idx_clear = 1'b1;
                                state_next     = S_COPY;
                            end
                            else
                            begin
                                ctrl.out_load = 1'b1;
                            end
                        end
                        KIND_NEWLINE:
                        begin
                            if (stat.last_row)
                            begin
                                ctrl.idx_clear = 1'b1;
                                state_next     = S_COPY;
                            end
                            else
                            begin
                                ctrl.out_load = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            ctrl.idx_clear = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        KIND_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            ctrl.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ctrl.out_load = 1'b1;
                ctrl.out_cell = 1'b1;
                state_next    = S_IDLE;
            end
            S_COPY:
            begin
                ctrl.walk = WALK_COPY;
                if (stat.copy_end)
                begin
                    ctrl.idx_to_blank = 1'b1;
                    state_next        = S_BLANK;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_BLANK:
            begin
                ctrl.walk = WALK_ZERO;
                if (stat.walk_end)
                begin
                    state_next = S_DONE_SCROLL;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_DONE_SCROLL:
            begin
                ctrl.out_load   = 1'b1;
                ctrl.out_scroll = 1'b1;
                state_next      = S_IDLE;
            end
            S_CLEAR:
            begin
                ctrl.walk = WALK_FILL;
                if (stat.walk_end)
                begin
                    state_next = S_DONE_CLEAR;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_DONE_CLEAR:
            begin
                ctrl.out_load = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response valid: set on load, dropped when taken
    always_comb
    begin
        if (ctrl.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

endmodule

@@ hdl/tcw_datapath.sv @@
// console datapath: cursor, colors, screen store and response register
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [KIND_W-1:0]     kind,
    input  logic [CHAR_W-1:0]     character,
    input  logic [COL_W-1:0]      column,
    input  logic [ROW_W-1:0]      row,
    input  ctrl_t                 ctrl,
    output status_t               stat,
    output logic [COL_W-1:0]      cursor_column,
    output logic [ROW_W-1:0]      cursor_row,
    output logic                  did_scroll,
    output logic [CHAR_W-1:0]     cell_character,
    output logic [COLOR_W-1:0]    cell_foreground,
    output logic [COLOR_W-1:0]    cell_background
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CX_W   = $clog2(COLUMNS);
    localparam int CY_W   = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END    = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BLANK_START = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(COLUMNS);
    localparam logic [CX_W-1:0]   LAST_CX     = CX_W'(COLUMNS - 1);
    localparam logic [CY_W-1:0]   LAST_CY     = CY_W'(ROWS - 1);

    logic [CX_W-1:0]    cx_reg;
    logic [CX_W-1:0]    cx_next;
    logic [CY_W-1:0]    cy_reg;
    logic [CY_W-1:0]    cy_next;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic               wr_pend_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic               wr_copy_reg;
    logic [CELL_W-1:0]  wr_data_reg;
    logic [CELL_W-1:0]  fill_reg;
    logic               rd_ok_reg;

    logic [COL_W-1:0]   rsp_col_reg;
    logic [ROW_W-1:0]   rsp_row_reg;
    logic               rsp_scroll_reg;
    logic [CHAR_W-1:0]  rsp_char_reg;
    logic [COLOR_W-1:0] rsp_fg_reg;
    logic [COLOR_W-1:0] rsp_bg_reg;

    logic               in_range;
    logic               put_we;
    logic [ADDR_W-1:0]  put_addr;
    logic [ADDR_W-1:0]  in_addr;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    // target cell of a move or read lies on the screen
    assign in_range = (32'(column) < 32'(COLUMNS)) && (32'(row) < 32'(ROWS));

    // linear cell addresses
    assign put_addr = ADDR_W'(cy_reg) * ROW_STEP + ADDR_W'(cx_reg);
    assign in_addr  = ADDR_W'(row) * ROW_STEP + ADDR_W'(column);

    // cursor update for an accepted word
    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (ctrl.accept)
        begin
            case (kind)
                KIND_PUT:
                begin
                    if (cx_reg == LAST_CX)
                    begin
                        cx_next = '0;
                        if (cy_reg != LAST_CY)
                        begin
                            cy_next = cy_reg + CY_W'(1);
                        end
                    end
                    else
                    begin
                        cx_next = cx_reg + CX_W'(1);
                    end
                end
                KIND_NEWLINE:
                begin
                    cx_next = '0;
                    if (cy_reg != LAST_CY)
                    begin
                        cy_next = cy_reg + CY_W'(1);
                    end
                end
                KIND_MOVE:
                begin
                    if (in_range)
                    begin
                        cx_next = CX_W'(column);
                        cy_next = CY_W'(row);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control registers: cursor, colors, walk index, pending walk write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg      <= '0;
            cy_reg      <= '0;
            fg_reg      <= FG_RESET;
            bg_reg      <= BG_RESET;
            idx_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_FG)
                begin
                    fg_reg <= cfg_data;
                end
                else
                begin
                    bg_reg <= cfg_data;
                end
            end
            if (ctrl.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.idx_to_blank)
            begin
                idx_reg <= BLANK_START;
            end
            else if (ctrl.idx_inc)
            begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
            wr_pend_reg <= (ctrl.walk != WALK_NONE);
        end
    end

    // walk write stage, clear fill word and read range flag
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= idx_reg;
        wr_copy_reg <= (ctrl.walk == WALK_COPY);
        wr_data_reg <= (ctrl.walk == WALK_FILL) ? fill_reg : '0;
        if (ctrl.accept && kind == KIND_CLEAR)
        begin
            fill_reg <= {BLANK_SPACE, bg_reg, fg_reg};
        end
        if (ctrl.accept)
        begin
            rd_ok_reg <= in_range;
        end
    end

    // store ports: walk write wins, else a put at accept
    assign put_we    = ctrl.accept && (kind == KIND_PUT);
    assign ram_we    = wr_pend_reg || put_we;
    assign ram_waddr = wr_pend_reg ? wr_addr_reg : put_addr;
    assign ram_wdata = wr_pend_reg ? (wr_copy_reg ? ram_rdata : wr_data_reg)
                                   : {character, bg_reg, fg_reg};
    assign ram_raddr = (ctrl.walk == WALK_COPY) ? idx_reg + ROW_STEP : in_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // response register
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            rsp_col_reg    <= COL_W'(cx_next);
            rsp_row_reg    <= ROW_W'(cy_next);
            rsp_scroll_reg <= ctrl.out_scroll;
            if (ctrl.out_cell && rd_ok_reg)
            begin
                rsp_char_reg <= ram_rdata[CELL_W-1 -: CHAR_W];
                rsp_bg_reg   <= ram_rdata[2*COLOR_W-1 -: COLOR_W];
                rsp_fg_reg   <= ram_rdata[COLOR_W-1:0];
            end
            else
            begin
                rsp_char_reg <= '0;
                rsp_bg_reg   <= '0;
                rsp_fg_reg   <= '0;
            end
        end
    end

    // status to the controller
    assign stat.wrap_col = (cx_reg == LAST_CX);
    assign stat.last_row = (cy_reg == LAST_CY);
    assign stat.copy_end = (idx_reg == COPY_END);
    assign stat.walk_end = (idx_reg == LAST_ADDR);

    assign cursor_column   = rsp_col_reg;
    assign cursor_row      = rsp_row_reg;
    assign did_scroll      = rsp_scroll_reg;
    assign cell_character  = rsp_char_reg;
    assign cell_foreground = rsp_fg_reg;
    assign cell_background = rsp_bg_reg;

endmodule

@@ hdl/text_console_writer_core.sv @@
// Text console writer top level.
// Keeps a COLUMNS x ROWS screen of character and color cells plus a cursor.
// cmd carries one command per word (put char, new line, move cursor, clear
// screen, read cell); rsp returns exactly one word per command with the
// cursor after it, a scroll flag and, for a read, the cell contents.
// cfg_wr_en/cfg_index/cfg_data write the foreground (index 0) and background
// (index 1) colors; write them only while no command is in flight.
// Put char and new line without a scroll, move and unused kinds give their
// response in the cycle after acceptance and can be taken every cycle while
// rsp is taken; a read also passes through S_READ, bound by the registered
// read of the screen memory. A put or new line that runs off the last row
// scrolls: the single-write-port memory walk copies one cell per cycle in
// S_COPY, blanks the last row in S_BLANK and loads the response in
// S_DONE_SCROLL; clear screen walks S_CLEAR, then S_DONE_CLEAR. After reset
// the memory is zeroed by a walk in S_INIT; cmd is not ready until S_IDLE.
// A stalled rsp holds its word; cmd is ready again once rsp is taken.
`timescale 1ns / 1ps

module text_console_writer_core import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tcw_cmd_if.sink               cmd,
    tcw_rsp_if.source             rsp
);

    ctrl_t   ctrl;
    status_t stat;

    // sequencing and handshakes
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .kind      (cmd.kind),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // cursor, colors, store and response payload
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (cmd.kind),
        .character       (cmd.character),
        .column          (cmd.column),
        .row             (cmd.row),
        .ctrl            (ctrl),
        .stat            (stat),
        .cursor_column   (rsp.cursor_column),
        .cursor_row      (rsp.cursor_row),
        .did_scroll      (rsp.did_scroll),
        .cell_character  (rsp.cell_character),
        .cell_foreground (rsp.cell_foreground),
        .cell_background (rsp.cell_background)
    );

endmodule

@@ dv/tb_text_console_writer_core.sv @@
// testbench for the text console writer: directed and random commands with a screen predictor
`timescale 1ns / 1ps

module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RSP_HOLD_LEN = 400;
    localparam int SETTLE       = 100;
    localparam int PHASE_WORDS  = 300;
    localparam int HEAVY_BUDGET = 15;

    // kinds the block must ignore
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_W'(KIND_READ + 1);
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] character;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } console_cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]   cursor_column;
        logic [ROW_W-1:0]   cursor_row;
        logic               did_scroll;
        logic [CHAR_W-1:0]  cell_character;
        logic [COLOR_W-1:0] cell_foreground;
        logic [COLOR_W-1:0] cell_background;
    } console_rsp_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tcw_cmd_if cmd_bus ();
    tcw_rsp_if rsp_bus ();

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .rsp       (rsp_bus)
    );

    // predicted screen, cursor and colors
    logic [CHAR_W-1:0]    scr_char [CELLS];
    logic [2*COLOR_W-1:0] scr_color [CELLS];
    int                   cur_col;
    int                   cur_row;
    logic [COLOR_W-1:0]   fg_color;
    logic [COLOR_W-1:0]   bg_color;

    console_rsp_t expected_rsp [$];
    int           mismatches;
    int           heavy_left;
    int           cycle_count;
    idle_mode_t   idle_mode;
    int           idle_pct;
    int           hold_req_id;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // move down one line, scrolling the screen off the bottom
    function automatic logic advance_line();
        int i;
        cur_row++;
        if (cur_row < ROWS)
            return 1'b0;
        for (i = 0; i < COLUMNS * (ROWS - 1); i++)
        begin
            scr_char[i]  = scr_char[i + COLUMNS];
            scr_color[i] = scr_color[i + COLUMNS];
        end
        for (i = COLUMNS * (ROWS - 1); i < CELLS; i++)
        begin
            scr_char[i]  = '0;
            scr_color[i] = '0;
        end
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    // apply one command to the predicted screen and build its response word
    function automatic console_rsp_t step_console(console_cmd_t c);
        console_rsp_t r;
        int           idx;
        r = '0;
        case (c.kind)
            KIND_PUT:
            begin
                idx = cur_row * COLUMNS + cur_col;
                scr_char[idx]  = c.character;
                scr_color[idx] = {bg_color, fg_color};
                cur_col++;
                if (cur_col >= COLUMNS)
                begin
                    cur_col      = 0;
                    r.did_scroll = advance_line();
                end
            end
            KIND_NEWLINE:
            begin
                cur_col      = 0;
                r.did_scroll = advance_line();
            end
            KIND_MOVE:
            begin
                if (int'(c.column) < COLUMNS && int'(c.row) < ROWS)
                begin
                    cur_col = int'(c.column);
                    cur_row = int'(c.row);
                end
            end
            KIND_CLEAR:
            begin
                for (idx = 0; idx < CELLS; idx++)
                begin
                    scr_char[idx]  = BLANK_SPACE;
                    scr_color[idx] = {bg_color, fg_color};
                end
            end
            KIND_READ:
            begin
                if (int'(c.column) < COLUMNS && int'(c.row) < ROWS)
                begin
                    idx               = int'(c.row) * COLUMNS + int'(c.column);
                    r.cell_character  = scr_char[idx];
                    r.cell_foreground = scr_color[idx][COLOR_W-1:0];
                    r.cell_background = scr_color[idx][2*COLOR_W-1:COLOR_W];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_column = COL_W'(cur_col);
        r.cursor_row    = ROW_W'(cur_row);
        return r;
    endfunction

    function automatic console_cmd_t make_cmd(logic [KIND_W-1:0] kind, int ch, int col, int row);
        console_cmd_t c;
        c.kind      = kind;
        c.character = CHAR_W'(ch);
        c.column    = COL_W'(col);
        c.row       = ROW_W'(row);
        return c;
    endfunction

    // point most moves and reads at the right edge, the bottom row or the cursor row
    function automatic console_cmd_t aim_cell(console_cmd_t c);
        console_cmd_t a;
        a = c;
        if ($urandom_range(99) < 8)
            return a;
        a.column = ($urandom_range(99) < 30) ? COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 3))
                                             : COL_W'($urandom_range(COLUMNS - 1));
        case ($urandom_range(3))
            0:       a.row = ROW_W'(ROWS - 1);
            1:       a.row = ROW_W'(cur_row);
            default: a.row = ROW_W'($urandom_range(ROWS - 1));
        endcase
        return a;
    endfunction

    // random command; scrolls and clears are kept within the phase budget
    function automatic console_cmd_t pick_command();
        console_cmd_t c;
        int           roll;
        logic         heavy;
        roll        = $urandom_range(99);
        c.kind      = KIND_PUT;
        c.character = CHAR_W'($urandom_range(2**CHAR_W - 1));
        c.column    = COL_W'($urandom_range(2**COL_W - 1));
        c.row       = ROW_W'($urandom_range(2**ROW_W - 1));
        if (roll < 50)
            c.kind = KIND_PUT;
        else if (roll < 58)
            c.kind = KIND_NEWLINE;
        else if (roll < 72)
        begin
            c.kind = KIND_MOVE;
            c      = aim_cell(c);
        end
        else if (roll < 94)
        begin
            c.kind = KIND_READ;
            c      = aim_cell(c);
        end
        else if (roll < 96)
            c.kind = KIND_CLEAR;
        else
            c.kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));

        heavy = (c.kind == KIND_CLEAR) ||
                (cur_row == ROWS - 1 && (c.kind == KIND_NEWLINE ||
                 (c.kind == KIND_PUT && cur_col == COLUMNS - 1)));
        if (heavy && heavy_left == 0)
        begin
            c.kind   = KIND_MOVE;
            c.column = COL_W'($urandom_range(COLUMNS - 1));
            c.row    = ROW_W'($urandom_range(ROWS - 2));
        end
        else if (heavy)
            heavy_left--;
        return c;
    endfunction

    // offer one command word, with random idle cycles ahead of it
    task automatic send_cmd(input console_cmd_t c);
        while ((idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) &&
               $urandom_range(99) < idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.kind      <= c.kind;
        cmd_bus.character <= c.character;
        cmd_bus.column    <= c.column;
        cmd_bus.row       <= c.row;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        expected_rsp.push_back(step_console(c));
    endtask

    // stop offering and wait for every outstanding response
    task automatic wait_drain();
        cmd_bus.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // write both color registers while the block is idle
    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FG;
        cfg_data  <= fg;
        @(posedge clk);
        fg_color = fg;
        cfg_index <= CFG_BG;
        cfg_data  <= bg;
        @(posedge clk);
        bg_color = bg;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t mode, input int pct);
        idle_mode = mode;
        idle_pct  = pct;
    endtask

    // response sink: long hold-off on request, otherwise random stalls
    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left    = 0;
        hold_seen     = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req_id != hold_seen)
            begin
                hold_seen  = hold_req_id;
                stall_left = RSP_HOLD_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= !((idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) &&
                                   $urandom_range(99) < idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare each response word with the oldest prediction
    always @(posedge clk)
    begin
        console_rsp_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response word with no command outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("cursor_column", 32'(want.cursor_column),
                            32'(rsp_bus.cursor_column));
                check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_bus.cursor_row));
                check_field("did_scroll", 32'(want.did_scroll), 32'(rsp_bus.did_scroll));
                check_field("cell_character", 32'(want.cell_character),
                            32'(rsp_bus.cell_character));
                check_field("cell_foreground", 32'(want.cell_foreground),
                            32'(rsp_bus.cell_foreground));
                check_field("cell_background", 32'(want.cell_background),
                            32'(rsp_bus.cell_background));
            end
        end
    end

    // reset contents, edges of the fields, ignored moves, scrolls and a clear
    task automatic test_directed_cases();
        set_idling(IDLE_NONE, 0);
        send_cmd(make_cmd(KIND_READ, 0, 0, 0));
        send_cmd(make_cmd(KIND_READ, 0, COLUMNS - 1, ROWS - 1));
        send_cmd(make_cmd(KIND_PUT, 8'h00, 0, 0));
        send_cmd(make_cmd(KIND_PUT, 8'hff, 2**COL_W - 1, 2**ROW_W - 1));
        send_cmd(make_cmd(KIND_READ, 8'hff, 0, 0));
        send_cmd(make_cmd(KIND_READ, 0, 1, 0));
        send_cmd(make_cmd(KIND_READ, 0, 2**COL_W - 1, 0));
        send_cmd(make_cmd(KIND_READ, 0, 0, 2**ROW_W - 1));
        send_cmd(make_cmd(KIND_MOVE, 0, COLUMNS - 1, ROWS - 1));
        send_cmd(make_cmd(KIND_MOVE, 0, COLUMNS, 0));
        send_cmd(make_cmd(KIND_MOVE, 0, 0, ROWS));
        send_cmd(make_cmd(KIND_SPARE_FIRST, 8'hff, 2**COL_W - 1, 2**ROW_W - 1));
        send_cmd(make_cmd(KIND_SPARE_LAST, 8'h55, 0, 0));
        // put at the last cell wraps and scrolls
        send_cmd(make_cmd(KIND_PUT, 8'h41, 0, 0));
        send_cmd(make_cmd(KIND_READ, 0, COLUMNS - 1, ROWS - 2));
        send_cmd(make_cmd(KIND_READ, 0, 0, ROWS - 1));
        // new line on the bottom row scrolls
        send_cmd(make_cmd(KIND_NEWLINE, 0, 0, 0));
        send_cmd(make_cmd(KIND_MOVE, 0, 0, 0));
        send_cmd(make_cmd(KIND_NEWLINE, 0, 0, 0));
        send_cmd(make_cmd(KIND_CLEAR, 0, 0, 0));
        send_cmd(make_cmd(KIND_READ, 0, COLUMNS / 2, ROWS / 2));
        // wrap at the right edge without a scroll
        send_cmd(make_cmd(KIND_MOVE, 0, COLUMNS - 1, 0));
        send_cmd(make_cmd(KIND_PUT, 8'haa, 0, 0));
        send_cmd(make_cmd(KIND_READ, 0, COLUMNS - 1, 0));
    endtask

    // color extremes written and read back, one clear under new colors
    task automatic test_color_settings();
        logic [COLOR_W-1:0] fg_list [5] = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd9};
        logic [COLOR_W-1:0] bg_list [5] = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd6};
        int i;
        for (i = 0; i < 5; i++)
        begin
            set_colors(fg_list[i], bg_list[i]);
            send_cmd(make_cmd(KIND_MOVE, 0, i, i));
            send_cmd(make_cmd(KIND_PUT, $urandom_range(2**CHAR_W - 1), 0, 0));
            send_cmd(make_cmd(KIND_READ, 0, i, i));
            if (i == 0)
            begin
                send_cmd(make_cmd(KIND_CLEAR, 0, 0, 0));
                send_cmd(make_cmd(KIND_READ, 0, COLUMNS - 1, ROWS - 1));
            end
        end
    endtask

    // random traffic under each idling pattern, new colors per phase
    task automatic test_random_traffic();
        idle_mode_t modes [4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        int         pcts  [4] = '{0, 61, 61, 17};
        int         p;
        for (p = 0; p < 4; p++)
        begin
            set_colors(COLOR_W'($urandom_range(2**COLOR_W - 1)),
                       COLOR_W'($urandom_range(2**COLOR_W - 1)));
            set_idling(modes[p], pcts[p]);
            heavy_left = HEAVY_BUDGET;
            repeat (PHASE_WORDS)
                send_cmd(pick_command());
        end
    endtask

    // response side held off while commands keep coming
    task automatic test_backpressure();
        wait_drain();
        set_idling(IDLE_NONE, 0);
        heavy_left  = 1;
        hold_req_id = hold_req_id + 1;
        repeat (24)
            send_cmd(pick_command());
        wait_drain();
    endtask

    // short bursts, each one fully drained before the next
    task automatic test_drain_pause();
        set_idling(IDLE_BOTH, 17);
        heavy_left = 2;
        repeat (3)
        begin
            repeat (8)
                send_cmd(pick_command());
            wait_drain();
        end
    endtask

    initial
    begin
        int i;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_FG;
        cfg_data          = '0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.kind      = KIND_PUT;
        cmd_bus.character = '0;
        cmd_bus.column    = '0;
        cmd_bus.row       = '0;
        heavy_left        = 0;
        hold_req_id       = 0;
        idle_mode         = IDLE_NONE;
        idle_pct          = 0;
        cur_col           = 0;
        cur_row           = 0;
        fg_color          = FG_RESET;
        bg_color          = BG_RESET;
        for (i = 0; i < CELLS; i++)
        begin
            scr_char[i]  = '0;
            scr_color[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_color_settings();
        test_backpressure();
        test_random_traffic();
        test_drain_pause();

        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tcw_pkg.sv
hdl/tcw_cmd_if.sv
hdl/tcw_rsp_if.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer_core.sv
dv/tb_text_console_writer_core.sv
